### sv/beep_pattern_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Beep pattern sequencer assertion macros
// Shared assertion wrappers; they expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef BEEP_PATTERN_SEQUENCER_MACROS_SVH
`define BEEP_PATTERN_SEQUENCER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/bps_pkg.sv
// ----------------------------------------------------------------------------
// Beep pattern sequencer package
// Field widths, register indexes, pattern tables and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

  localparam int unsigned EV_W        = 5;
  localparam int unsigned HZ_W        = 12;
  localparam int unsigned MS_W        = 9;
  localparam int unsigned SEG_W       = 3;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 12;

  localparam int unsigned NUM_EVENTS       = 17;
  localparam int unsigned SEG_SLOTS        = 5;
  localparam int unsigned MAX_SEGMENTS_DEF = 5;

  localparam logic [HZ_W-1:0] OK_TONE_RESET = 12'd2700;

  localparam logic [0:0] ACT_TICK = 1'b0;
  localparam logic [0:0] ACT_POST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OK_TONE = 2'd1;

  typedef struct packed {
    logic            action;
    logic [EV_W-1:0] event_code;
  } step_t;

  typedef struct packed {
    logic            enabled;
    logic [HZ_W-1:0] ok_tone_hz;
  } cfg_t;

  typedef struct packed {
    logic            tone_on;
    logic [HZ_W-1:0] tone_freq_hz;
    logic            busy_res;
    logic            pattern_done;
  } res_t;

  localparam logic [SEG_W-1:0] SEG_COUNT [NUM_EVENTS] = '{
    3'd1, 3'd3, 3'd1, 3'd1, 3'd3, 3'd5, 3'd3, 3'd3, 3'd1,
    3'd3, 3'd1, 3'd1, 3'd5, 3'd3, 3'd5, 3'd3, 3'd1
  };

  // Tone frequencies for segments 0, 2 and 4; the ok event uses its register.
  localparam logic [HZ_W-1:0] TONE_HZ [NUM_EVENTS][3] = '{
    '{12'd0,    12'd0,    12'd0},    '{12'd2200, 12'd2200, 12'd0},
    '{12'd3200, 12'd0,    12'd0},    '{12'd1800, 12'd0,    12'd0},
    '{12'd3000, 12'd2200, 12'd0},    '{12'd2000, 12'd2600, 12'd3200},
    '{12'd2400, 12'd3000, 12'd0},    '{12'd3200, 12'd3600, 12'd0},
    '{12'd2000, 12'd0,    12'd0},    '{12'd3200, 12'd3200, 12'd0},
    '{12'd2500, 12'd0,    12'd0},    '{12'd2600, 12'd0,    12'd0},
    '{12'd2400, 12'd2800, 12'd3200}, '{12'd2000, 12'd2000, 12'd0},
    '{12'd1600, 12'd1600, 12'd1600}, '{12'd2800, 12'd3400, 12'd0},
    '{12'd1800, 12'd0,    12'd0}
  };

  localparam logic [MS_W-1:0] SEG_MS [NUM_EVENTS][SEG_SLOTS] = '{
    '{9'd120, 9'd0,  9'd0,   9'd0,  9'd0},   '{9'd80,  9'd60, 9'd80,  9'd0,  9'd0},
    '{9'd70,  9'd0,  9'd0,   9'd0,  9'd0},   '{9'd60,  9'd0,  9'd0,   9'd0,  9'd0},
    '{9'd55,  9'd45, 9'd75,  9'd0,  9'd0},   '{9'd45,  9'd35, 9'd45,  9'd35, 9'd70},
    '{9'd45,  9'd30, 9'd55,  9'd0,  9'd0},   '{9'd30,  9'd20, 9'd35,  9'd0,  9'd0},
    '{9'd30,  9'd0,  9'd0,   9'd0,  9'd0},   '{9'd40,  9'd35, 9'd40,  9'd0,  9'd0},
    '{9'd35,  9'd0,  9'd0,   9'd0,  9'd0},   '{9'd90,  9'd0,  9'd0,   9'd0,  9'd0},
    '{9'd55,  9'd40, 9'd55,  9'd40, 9'd80},  '{9'd55,  9'd50, 9'd55,  9'd0,  9'd0},
    '{9'd180, 9'd70, 9'd180, 9'd70, 9'd260}, '{9'd50,  9'd40, 9'd60,  9'd0,  9'd0},
    '{9'd130, 9'd0,  9'd0,   9'd0,  9'd0}
  };

  // Codes beyond the table fall back to the ok event.
  function automatic logic [EV_W-1:0] safe_event(input logic [EV_W-1:0] ev);
    return (ev < EV_W'(NUM_EVENTS)) ? ev : '0;
  endfunction

  function automatic logic [SEG_W-1:0] seg_count_f(input logic [EV_W-1:0] ev);
    return SEG_COUNT[safe_event(ev)];
  endfunction

  function automatic logic [MS_W-1:0] seg_ms_f(input logic [EV_W-1:0]  ev,
                                               input logic [SEG_W-1:0] seg);
    logic [MS_W-1:0] ms;
    ms = '0;
    if (seg < SEG_W'(SEG_SLOTS)) begin
      ms = SEG_MS[safe_event(ev)][seg];
    end
    return ms;
  endfunction

  function automatic logic [HZ_W-1:0] tone_hz_f(input logic [EV_W-1:0] ev,
                                                input logic [1:0]      tone_idx);
    logic [HZ_W-1:0] hz;
    hz = '0;
    if (tone_idx != 2'd3) begin
      hz = TONE_HZ[safe_event(ev)][tone_idx];
    end
    return hz;
  endfunction

endpackage

`default_nettype wire

### sv/bps_ifs.sv
// ----------------------------------------------------------------------------
// Beep pattern sequencer channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bps_in_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [bps_pkg::EV_W-1:0] event_code;

  modport source (output valid, action, event_code, input ready);
  modport sink   (input valid, action, event_code, output ready);
endinterface

interface bps_out_if;
  logic                     valid;
  logic                     ready;
  logic                     tone_on;
  logic [bps_pkg::HZ_W-1:0] tone_freq_hz;
  logic                     busy_res;
  logic                     pattern_done;

  modport source (output valid, tone_on, tone_freq_hz, busy_res, pattern_done,
                  input ready);
  modport sink   (input valid, tone_on, tone_freq_hz, busy_res, pattern_done,
                  output ready);
endinterface

interface bps_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bps_pkg::CFG_IDX_W-1:0]  index;
  logic [bps_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/bps_core.sv
// ----------------------------------------------------------------------------
// Beep pattern sequencer core
// Mailbox, segment counter and tone lookup, advanced once per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

`include "beep_pattern_sequencer_macros.svh"

module bps_core #(
  parameter int unsigned MaxSegments = bps_pkg::MAX_SEGMENTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  bps_pkg::step_t step,
  input  bps_pkg::cfg_t  cfg,
  output bps_pkg::res_t  res
);
  import bps_pkg::*;

  localparam logic [SEG_W:0] MAX_SEG_L = (SEG_W+1)'(MaxSegments);

  logic             pending_valid_r, pending_valid_nxt;
  logic [EV_W-1:0]  pending_event_r, pending_event_nxt;
  logic             playing_r, playing_nxt;
  logic [EV_W-1:0]  current_event_r, current_event_nxt;
  logic [SEG_W-1:0] segment_index_r, segment_index_nxt;
  logic [MS_W-1:0]  remaining_ms_r, remaining_ms_nxt;

  logic             start;
  logic             active;
  logic [EV_W-1:0]  ev_cur;
  logic [SEG_W-1:0] seg_cur;
  logic [MS_W-1:0]  rem_cur;
  logic [SEG_W:0]   seg_next;
  logic             last_seg;

  // A tick while idle takes the pending event and plays its first millisecond.
  assign start   = (step.action == ACT_TICK) && !playing_r && pending_valid_r;
  assign active  = playing_r || start;
  assign ev_cur  = start ? pending_event_r : current_event_r;
  assign seg_cur = start ? '0 : segment_index_r;
  assign rem_cur = start ? seg_ms_f(pending_event_r, '0) : remaining_ms_r;

  assign seg_next = {1'b0, seg_cur} + (SEG_W+1)'(1);
  assign last_seg = (seg_next >= {1'b0, seg_count_f(ev_cur)}) || (seg_next >= MAX_SEG_L);

  always_comb begin
    pending_valid_nxt = pending_valid_r;
    pending_event_nxt = pending_event_r;
    playing_nxt       = playing_r;
    current_event_nxt = current_event_r;
    segment_index_nxt = segment_index_r;
    remaining_ms_nxt  = remaining_ms_r;
    if (step.action == ACT_POST) begin
      if (cfg.enabled && (step.event_code < EV_W'(NUM_EVENTS))) begin
        pending_valid_nxt = 1'b1;
        pending_event_nxt = step.event_code;
      end
    end else begin
      if (start) begin
        pending_valid_nxt = 1'b0;
        current_event_nxt = pending_event_r;
        playing_nxt       = 1'b1;
      end
      if (active) begin
        if (rem_cur > MS_W'(1)) begin
          segment_index_nxt = seg_cur;
          remaining_ms_nxt  = rem_cur - MS_W'(1);
        end else if (last_seg) begin
          playing_nxt       = 1'b0;
          segment_index_nxt = '0;
          remaining_ms_nxt  = '0;
        end else begin
          segment_index_nxt = seg_next[SEG_W-1:0];
          remaining_ms_nxt  = seg_ms_f(ev_cur, seg_next[SEG_W-1:0]);
        end
      end
    end
  end

  // Even segments are tones, odd segments are gaps.
  always_comb begin
    res = '0;
    res.busy_res = active;
    if (active && cfg.enabled && (seg_cur < SEG_W'(SEG_SLOTS)) && !seg_cur[0]) begin
      res.tone_on      = 1'b1;
      res.tone_freq_hz = (safe_event(ev_cur) == '0) ? cfg.ok_tone_hz
                                                    : tone_hz_f(ev_cur, seg_cur[2:1]);
    end
    res.pattern_done = (step.action == ACT_TICK) && active && (rem_cur <= MS_W'(1))
                       && last_seg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_valid_r <= 1'b0;
      pending_event_r <= '0;
      playing_r       <= 1'b0;
      current_event_r <= '0;
      segment_index_r <= '0;
      remaining_ms_r  <= '0;
    end else if (step_en) begin
      pending_valid_r <= pending_valid_nxt;
      pending_event_r <= pending_event_nxt;
      playing_r       <= playing_nxt;
      current_event_r <= current_event_nxt;
      segment_index_r <= segment_index_nxt;
      remaining_ms_r  <= remaining_ms_nxt;
    end
  end

  `BPS_ASSERT_SAME(a_idle_cleared, !playing_r, (segment_index_r == '0) && (remaining_ms_r == '0), "idle sequencer holds a stale segment")
  `BPS_ASSERT_SAME(a_seg_bound, playing_r, segment_index_r < MaxSegments, "segment index beyond the segment limit")
  `BPS_ASSERT_NEXT(a_drop_post, step_en && (step.action == ACT_POST) && !cfg.enabled, (pending_valid_r == $past(pending_valid_r)) && (pending_event_r == $past(pending_event_r)), "post changed the mailbox while disabled")
  `BPS_ASSERT_SAME(a_done_ends, res.pattern_done, res.busy_res && !playing_nxt, "pattern end reported while still playing")

endmodule

`default_nettype wire

### sv/beep_pattern_sequencer.sv
// Latency: a result is valid in the cycle after its input transaction is accepted.
// Throughput: one item per cycle unless out_ch stalls; the output register frees itself in
// the cycle it is taken. The segment counter and pattern table lookup are combinational.
// Reset (synchronous, rst_n low) clears the mailbox and playback state, disables the
// block and sets the ok tone to 2700 Hz; no clearing pass follows.
// ----------------------------------------------------------------------------
// Beep pattern sequencer
// Plays millisecond-stepped buzzer patterns for posted events.
// ----------------------------------------------------------------------------
`default_nettype none

`include "beep_pattern_sequencer_macros.svh"

module beep_pattern_sequencer #(
  parameter int unsigned MAX_SEGMENTS = bps_pkg::MAX_SEGMENTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bps_in_if.sink    in_ch,
  bps_out_if.source out_ch,
  bps_cfg_if.sink   cfg_ch
);
  import bps_pkg::*;

  logic   in_acc;
  logic   cfg_acc;
  step_t  step;
  cfg_t   cfg_r;
  res_t   res;
  res_t   res_r;
  logic   out_valid_r, out_valid_nxt;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;

  assign step.action     = in_ch.action;
  assign step.event_code = in_ch.event_code;

  bps_core #(
    .MaxSegments (MAX_SEGMENTS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_acc),
    .step    (step),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled    <= 1'b0;
      cfg_r.ok_tone_hz <= OK_TONE_RESET;
    end else if (cfg_acc) begin
      case (cfg_ch.index)
        CFG_ENABLED: cfg_r.enabled    <= cfg_ch.data[0];
        CFG_OK_TONE: cfg_r.ok_tone_hz <= cfg_ch.data[HZ_W-1:0];
        default:     ;
      endcase
    end
  end

  assign out_valid_nxt = in_acc || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.tone_on      = res_r.tone_on;
  assign out_ch.tone_freq_hz = res_r.tone_freq_hz;
  assign out_ch.busy_res     = res_r.busy_res;
  assign out_ch.pattern_done = res_r.pattern_done;

  `BPS_ASSERT_NEXT(a_accept_loads, in_acc, out_valid_r, "accepted item produced no result")
  `BPS_ASSERT_SAME(a_no_overrun, out_valid_r && !out_ch.ready, !in_acc, "input taken while the result is stalled")
  `BPS_ASSERT_NEXT(a_hold_stalled, out_valid_r && !out_ch.ready, out_valid_r && $stable(res_r), "stalled result changed")

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Beep pattern sequencer testbench
// A table of directed transactions is followed by random posts and ticks over
// several register settings. Each result is checked against the value pinned in the
// directed table or else against a cycle-free model of the pattern player kept in this file.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bps_pkg::*;

  localparam int ITEMS_PER_PHASE = 118;
  localparam int NUM_PHASES      = 7;
  localparam int HOLD_CYCLES     = 80;
  localparam int IDLE_PCT        = 32;

  // Pattern tables, kept apart from the design's own copy.
  localparam logic [SEG_W-1:0] PAT_SEGS [NUM_EVENTS] = '{
    1, 3, 1, 1, 3, 5, 3, 3, 1, 3, 1, 1, 5, 3, 5, 3, 1
  };
  localparam logic [HZ_W-1:0] PAT_HZ [NUM_EVENTS][3] = '{
    '{0, 0, 0},          '{2200, 2200, 0},    '{3200, 0, 0},
    '{1800, 0, 0},       '{3000, 2200, 0},    '{2000, 2600, 3200},
    '{2400, 3000, 0},    '{3200, 3600, 0},    '{2000, 0, 0},
    '{3200, 3200, 0},    '{2500, 0, 0},       '{2600, 0, 0},
    '{2400, 2800, 3200}, '{2000, 2000, 0},    '{1600, 1600, 1600},
    '{2800, 3400, 0},    '{1800, 0, 0}
  };
  localparam logic [MS_W-1:0] PAT_MS [NUM_EVENTS][SEG_SLOTS] = '{
    '{120, 0, 0, 0, 0},    '{80, 60, 80, 0, 0},   '{70, 0, 0, 0, 0},
    '{60, 0, 0, 0, 0},     '{55, 45, 75, 0, 0},   '{45, 35, 45, 35, 70},
    '{45, 30, 55, 0, 0},   '{30, 20, 35, 0, 0},   '{30, 0, 0, 0, 0},
    '{40, 35, 40, 0, 0},   '{35, 0, 0, 0, 0},     '{90, 0, 0, 0, 0},
    '{55, 40, 55, 40, 80}, '{55, 50, 55, 0, 0},   '{180, 70, 180, 70, 260},
    '{50, 40, 60, 0, 0},   '{130, 0, 0, 0, 0}
  };

  typedef struct packed {
    logic            action;
    logic [EV_W-1:0] code;
    logic [9:0]      reps;
    logic            pinned;
    res_t            want;
  } dir_row_t;

  localparam int DIR_ROWS       = 21;
  localparam int DIR_ENABLE_ROW = 3;
  localparam res_t SILENT = '0;

  // Rows before DIR_ENABLE_ROW run with the block disabled as it comes out of reset;
  // the rest run enabled with the ok tone at its top value.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{ACT_TICK, 5'd0,  10'd1,   1'b1, SILENT},
    '{ACT_POST, 5'd5,  10'd1,   1'b1, SILENT},
    '{ACT_TICK, 5'd31, 10'd1,   1'b1, SILENT},
    '{ACT_POST, 5'd31, 10'd1,   1'b1, SILENT},
    '{ACT_TICK, 5'd0,  10'd1,   1'b1, SILENT},
    '{ACT_POST, 5'd17, 10'd1,   1'b1, SILENT},
    '{ACT_POST, 5'd0,  10'd1,   1'b1, SILENT},
    '{ACT_TICK, 5'd0,  10'd1,   1'b1, '{1'b1, 12'd4095, 1'b1, 1'b0}},
    '{ACT_POST, 5'd16, 10'd1,   1'b1, '{1'b1, 12'd4095, 1'b1, 1'b0}},
    '{ACT_POST, 5'd14, 10'd1,   1'b1, '{1'b1, 12'd4095, 1'b1, 1'b0}},
    '{ACT_TICK, 5'd0,  10'd118, 1'b0, SILENT},
    '{ACT_TICK, 5'd0,  10'd1,   1'b1, '{1'b1, 12'd4095, 1'b1, 1'b1}},
    '{ACT_TICK, 5'd0,  10'd1,   1'b1, '{1'b1, 12'd1600, 1'b1, 1'b0}},
    '{ACT_TICK, 5'd0,  10'd179, 1'b0, SILENT},
    '{ACT_TICK, 5'd0,  10'd1,   1'b1, '{1'b0, 12'd0,    1'b1, 1'b0}},
    '{ACT_POST, 5'd8,  10'd1,   1'b0, SILENT},
    '{ACT_TICK, 5'd0,  10'd578, 1'b0, SILENT},
    '{ACT_TICK, 5'd0,  10'd1,   1'b1, '{1'b1, 12'd1600, 1'b1, 1'b1}},
    '{ACT_TICK, 5'd0,  10'd1,   1'b1, '{1'b1, 12'd2000, 1'b1, 1'b0}},
    '{ACT_TICK, 5'd0,  10'd29,  1'b0, SILENT},
    '{ACT_TICK, 5'd0,  10'd1,   1'b1, SILENT}
  };

  logic clk = 1'b0;
  logic rst_n;

  bps_in_if  in_if();
  bps_out_if out_if();
  bps_cfg_if cfg_if();

  beep_pattern_sequencer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register mirror and player state.
  bit               en_mirror;
  logic [HZ_W-1:0]  ok_hz_mirror;
  bit               mbox_valid;
  logic [EV_W-1:0]  mbox_event;
  bit               playing;
  logic [EV_W-1:0]  cur_ev;
  logic [SEG_W-1:0] seg_idx;
  logic [MS_W-1:0]  ms_left;

  res_t tone_reports_q[$];
  int   mismatches;

  bit tx_steady;
  bit rx_steady;
  bit hold_req;
  int hold_left;

  function automatic res_t segment_sound();
    res_t r;
    r = '0;
    if (en_mirror && seg_idx < SEG_SLOTS && !seg_idx[0]) begin
      r.tone_on      = 1'b1;
      r.tone_freq_hz = (cur_ev == '0) ? ok_hz_mirror : PAT_HZ[cur_ev][seg_idx >> 1];
    end
    return r;
  endfunction

  function automatic logic [MS_W-1:0] segment_ms(input logic [SEG_W-1:0] seg);
    return (seg < SEG_SLOTS) ? PAT_MS[cur_ev][seg] : '0;
  endfunction

  task automatic step_player(input step_t it, output res_t r);
    logic [SEG_W-1:0] nsegs;
    r = '0;
    if (it.action == ACT_POST) begin
      if (en_mirror && it.event_code < NUM_EVENTS) begin
        mbox_event = it.event_code;
        mbox_valid = 1'b1;
      end
      if (playing) r = segment_sound();
      r.busy_res = playing;
    end else begin
      if (!playing && mbox_valid) begin
        playing    = 1'b1;
        cur_ev     = mbox_event;
        mbox_valid = 1'b0;
        seg_idx    = '0;
        ms_left    = segment_ms('0);
      end
      if (playing) begin
        r          = segment_sound();
        r.busy_res = 1'b1;
        nsegs = (PAT_SEGS[cur_ev] < MAX_SEGMENTS_DEF) ? PAT_SEGS[cur_ev]
                                                       : SEG_W'(MAX_SEGMENTS_DEF);
        if (ms_left > 1) begin
          ms_left = ms_left - 1'b1;
        end else if (4'(seg_idx) + 4'd1 >= 4'(nsegs)) begin
          playing        = 1'b0;
          r.pattern_done = 1'b1;
          seg_idx        = '0;
          ms_left        = '0;
        end else begin
          seg_idx = seg_idx + 1'b1;
          ms_left = segment_ms(seg_idx);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Valid stays high from one transaction to the next unless a gap is drawn.
  task automatic send_item(input step_t it, input bit pinned, input res_t pin);
    res_t want;
    if (!tx_steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_if.valid      <= 1'b1;
    in_if.action     <= it.action;
    in_if.event_code <= it.event_code;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    step_player(it, want);
    tone_reports_q.push_back(pinned ? pin : want);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (tone_reports_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_regs(input bit en, input logic [HZ_W-1:0] hz);
    logic [CFG_DATA_W-1:0] en_word;
    en_word    = CFG_DATA_W'($urandom_range(4095));
    en_word[0] = en;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_ENABLED;
    cfg_if.data  <= en_word;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    en_mirror = en;
    cfg_if.index <= CFG_OK_TONE;
    cfg_if.data  <= hz;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    ok_hz_mirror = hz;
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly ticks so that patterns run out; posts are sometimes out of range.
  function automatic step_t random_item();
    step_t it;
    it.action = ($urandom_range(99) < 12) ? ACT_POST : ACT_TICK;
    if (it.action == ACT_POST && $urandom_range(99) < 85) begin
      it.event_code = EV_W'($urandom_range(NUM_EVENTS - 1, 0));
    end else begin
      it.event_code = EV_W'($urandom_range(31, 0));
    end
    return it;
  endfunction

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (rx_steady) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.tone_on, out_if.tone_freq_hz, out_if.busy_res, out_if.pattern_done};
      if (tone_reports_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result on=%0d hz=%0d busy=%0d done=%0d",
                                  got.tone_on, got.tone_freq_hz, got.busy_res,
                                  got.pattern_done));
      end else begin
        want = tone_reports_q.pop_front();
        if (got.tone_on !== want.tone_on || got.tone_freq_hz !== want.tone_freq_hz ||
            got.busy_res !== want.busy_res || got.pattern_done !== want.pattern_done) begin
          report_mismatch($sformatf(
            "expected on=%0d hz=%0d busy=%0d done=%0d, got on=%0d hz=%0d busy=%0d done=%0d",
            want.tone_on, want.tone_freq_hz, want.busy_res, want.pattern_done,
            got.tone_on, got.tone_freq_hz, got.busy_res, got.pattern_done));
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    bit              phase_en  [NUM_PHASES];
    logic [HZ_W-1:0] phase_hz  [NUM_PHASES];
    step_t           it;

    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.action     = ACT_TICK;
    in_if.event_code = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_ENABLED;
    cfg_if.data      = '0;

    en_mirror    = 1'b0;
    ok_hz_mirror = OK_TONE_RESET;
    mbox_valid   = 1'b0;
    mbox_event   = '0;
    playing      = 1'b0;
    cur_ev       = '0;
    seg_idx      = '0;
    ms_left      = '0;
    mismatches   = 0;
    tx_steady    = 1'b0;
    rx_steady    = 1'b0;
    hold_req     = 1'b0;
    hold_left    = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (r == DIR_ENABLE_ROW) begin
        drain_results();
        write_regs(1'b1, 12'd4095);
      end
      it.action     = DIRECTED[r].action;
      it.event_code = DIRECTED[r].code;
      for (int k = 0; k < int'(DIRECTED[r].reps); k++) begin
        send_item(it, DIRECTED[r].pinned, DIRECTED[r].want);
      end
    end

    // The ok tone runs through both ends of its range and zero, which passes through.
    phase_en = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    phase_hz = '{12'd2700, 12'd1, 12'd4095, 12'd0,
                 HZ_W'($urandom_range(4095, 1)), HZ_W'($urandom_range(4095, 1)), 12'd4095};

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_regs(phase_en[p], phase_hz[p]);
      tx_steady = (p == 0);
      rx_steady = (p == 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // The receiver backs off for a while so that the block fills and stalls its input.
        if (p == 0 && i == 60) hold_req = 1'b1;
        if (p == 2 && i == 100) drain_results();
        send_item(random_item(), 1'b0, SILENT);
      end
    end

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    in_if.valid <= 1'b0;
    while (tone_reports_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
